FILE: hdl/iuc_pkg.sv
// Shared types and codes for the interval union coverage block.
// No dependencies; imported by iuc_cell and interval_union_coverage.
package iuc_pkg;

  // result status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_BAD  = 2'd2;

  // control flags of the token that sweeps down the cell row
  typedef struct packed {
    logic valid;  // token present at this cell boundary
    logic found;  // a free slot has been seen upstream
  } tok_ctl_t;

endpackage

FILE: hdl/iuc_cell.sv
// One table slot of the coverage row: holds a stored range and folds it into
// the passing sweep token. Depends on iuc_pkg.
module iuc_cell #(
  parameter int PW  = 32,
  parameter int IW  = 6,
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [PW-1:0]     req_lo,
  input  logic [PW-1:0]     req_hi,
  input  iuc_pkg::tok_ctl_t in_ctl,
  input  logic [PW-1:0]     in_lo,
  input  logic [PW-1:0]     in_hi,
  input  logic [PW-1:0]     in_sub,
  input  logic [CW-1:0]     in_hits,
  input  logic [IW-1:0]     in_idx,
  output iuc_pkg::tok_ctl_t out_ctl,
  output logic [PW-1:0]     out_lo,
  output logic [PW-1:0]     out_hi,
  output logic [PW-1:0]     out_sub,
  output logic [CW-1:0]     out_hits,
  output logic [IW-1:0]     out_idx,
  input  logic              wr_en,
  input  logic [IW-1:0]     wr_idx,
  input  logic [PW-1:0]     wr_lo,
  input  logic [PW-1:0]     wr_hi,
  output logic              occupied
);
  import iuc_pkg::*;

  logic          used;
  logic [PW-1:0] s;
  logic [PW-1:0] e;
  logic [PW:0]   hi_p1;
  logic [PW:0]   e_p1;
  logic          hit;
  logic          free_here;
  logic [PW-1:0] len;

  assign hi_p1     = {1'b0, req_hi} + {{PW{1'b0}}, 1'b1};
  assign e_p1      = {1'b0, e} + {{PW{1'b0}}, 1'b1};
  // overlap or adjacency with the request
  assign hit       = in_ctl.valid && used && ({1'b0, s} <= hi_p1) && ({1'b0, req_lo} <= e_p1);
  assign free_here = !used || hit;
  assign len       = e - s + {{(PW-1){1'b0}}, 1'b1};
  assign occupied  = used;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (hit) begin
      used <= 1'b0;
    end else if (wr_en && wr_idx == IW'(IDX)) begin
      used <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_idx == IW'(IDX)) begin
      s <= wr_lo;
      e <= wr_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl.valid <= in_ctl.valid;
      out_ctl.found <= in_ctl.found || (in_ctl.valid && free_here);
    end
  end

  always_ff @(posedge clk) begin
    out_lo   <= (hit && s < in_lo) ? s : in_lo;
    out_hi   <= (hit && e > in_hi) ? e : in_hi;
    out_sub  <= hit ? in_sub + len : in_sub;
    out_hits <= hit ? in_hits + {{(CW-1){1'b0}}, 1'b1} : in_hits;
    out_idx  <= (!in_ctl.found && free_here) ? IW'(IDX) : in_idx;
  end

endmodule

FILE: hdl/interval_union_coverage.sv
// Interval union coverage, top level: request control, covered total and
// result register around a row of iuc_cell slots. Depends on iuc_pkg, iuc_cell.
//
// Usage
//   s_* : one word per range, tdata[31:0] range_start, tdata[63:32] range_end.
//   m_* : one word per range, tdata[31:0] uncovered_cells, tdata[38:32]
//         range_count (upper bits zero), tuser[1:0] status.
//   cfg_*: writes total_cells; allowed only while the block is idle.
//   A range is taken only while the block is idle. A bad range goes straight
//   to the emit state, which loads its result. A good range launches a token
//   that walks the slot row one cell per cycle, merging every touching range,
//   recording the first free slot and the removed length; the merged range is
//   written back when the token leaves the last cell, if a free slot was seen.
//   The result is then loaded in the emit state, and a new range can be taken
//   the cycle after the result is loaded; the block works on one range at a
//   time, and its sweep time is set by the length of the slot row.
//   If m_tready is low the result is held and the block waits before loading
//   the next one; one finished item may be held while another is in work.
//   Reset empties the table, clears the covered total and sets total_cells to
//   all ones.
module interval_union_coverage #(
  parameter int MAX_RANGES    = 64,
  parameter int POSITION_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // range_start[31:0], range_end[63:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // uncovered_cells[31:0], range_count[38:32], pad
  output logic [1:0]  m_tuser,   // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import iuc_pkg::*;

  localparam int PW = POSITION_BITS;
  localparam int IW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0]    state;
  logic [PW-1:0] total_cells;
  logic [PW-1:0] covered;
  logic [CW-1:0] count;
  logic [PW-1:0] req_lo;
  logic [PW-1:0] req_hi;
  logic [1:0]    status;
  logic          launch;

  tok_ctl_t      ctl   [MAX_RANGES+1];
  logic [PW-1:0] t_lo  [MAX_RANGES+1];
  logic [PW-1:0] t_hi  [MAX_RANGES+1];
  logic [PW-1:0] t_sub [MAX_RANGES+1];
  logic [CW-1:0] t_hits[MAX_RANGES+1];
  logic [IW-1:0] t_idx [MAX_RANGES+1];
  logic [MAX_RANGES-1:0] occ;

  logic          accept;
  logic [31:0]   in_lo;
  logic [31:0]   in_hi;
  logic          bad;
  logic          fin;
  logic          wr_en;
  logic [PW-1:0] fin_len;
  logic [PW-1:0] unc;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign in_lo     = s_tdata[31:0];
  assign in_hi     = s_tdata[63:32];
  assign bad       = (in_lo == 32'd0) || (in_lo > in_hi) || (in_hi > 32'(total_cells));

  assign ctl[0]    = '{valid: launch, found: 1'b0};
  assign t_lo[0]   = req_lo;
  assign t_hi[0]   = req_hi;
  assign t_sub[0]  = '0;
  assign t_hits[0] = '0;
  assign t_idx[0]  = '0;

  genvar g;
  generate
    for (g = 0; g < MAX_RANGES; g++) begin : g_cell
      iuc_cell #(.PW(PW), .IW(IW), .CW(CW), .IDX(g)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .req_lo   (req_lo),
        .req_hi   (req_hi),
        .in_ctl   (ctl[g]),
        .in_lo    (t_lo[g]),
        .in_hi    (t_hi[g]),
        .in_sub   (t_sub[g]),
        .in_hits  (t_hits[g]),
        .in_idx   (t_idx[g]),
        .out_ctl  (ctl[g+1]),
        .out_lo   (t_lo[g+1]),
        .out_hi   (t_hi[g+1]),
        .out_sub  (t_sub[g+1]),
        .out_hits (t_hits[g+1]),
        .out_idx  (t_idx[g+1]),
        .wr_en    (wr_en),
        .wr_idx   (t_idx[MAX_RANGES]),
        .wr_lo    (t_lo[MAX_RANGES]),
        .wr_hi    (t_hi[MAX_RANGES]),
        .occupied (occ[g])
      );
    end
  endgenerate

  // token leaving the last slot: no free slot means table full
  assign fin     = ctl[MAX_RANGES].valid;
  assign wr_en   = fin && ctl[MAX_RANGES].found;
  assign fin_len = t_hi[MAX_RANGES] - t_lo[MAX_RANGES] + {{(PW-1){1'b0}}, 1'b1};
  assign unc     = (total_cells > covered) ? total_cells - covered : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_cells <= PW'(32'hFFFF_FFFF);
    end else if (cfg_valid && cfg_ready) begin
      total_cells <= PW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_lo <= PW'(in_lo);
      req_hi <= PW'(in_hi);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      launch   <= 1'b0;
      covered  <= '0;
      count    <= '0;
      status   <= STATUS_OK;
      m_tvalid <= 1'b0;
    end else begin
      launch <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (bad) begin
              status <= STATUS_BAD;
              state  <= ST_EMIT;
            end else begin
              launch <= 1'b1;
              state  <= ST_SWEEP;
            end
          end
        end
        ST_SWEEP: begin
          if (fin) begin
            if (wr_en) begin
              covered <= covered - t_sub[MAX_RANGES] + fin_len;
              count   <= count - t_hits[MAX_RANGES] + {{(CW-1){1'b0}}, 1'b1};
              status  <= STATUS_OK;
            end else begin
              status  <= STATUS_FULL;
            end
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && (!m_tvalid || m_tready)) begin
      m_tdata <= {1'b0, 7'(count), 32'(unc)};
      m_tuser <= status;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("accepted range did not start work");

  a_token_in_sweep: assert property (@(posedge clk) disable iff (rst)
    fin |-> state == ST_SWEEP)
    else $error("sweep token outside sweep");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> $countones(occ) == int'(count))
    else $error("range count disagrees with occupied slots");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= MAX_RANGES)
    else $error("range count above table size");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for interval_union_coverage: sends ranges and total_cells writes, and
// checks every result word against its own interval table. Depends on iuc_pkg and the RTL.
module testbench;
  import iuc_pkg::*;

  localparam int SLOTS          = 64;
  localparam int ITEM_CYCLES    = SLOTS + 4;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [31:0] uncovered;
    logic [6:0]  count;
    logic [1:0]  status;
  } coverage_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  // interval table kept by the testbench
  bit          span_live [SLOTS];
  logic [31:0] span_lo [SLOTS];
  logic [31:0] span_hi [SLOTS];
  logic [31:0] covered_cells = '0;
  logic [31:0] line_cells = 32'hFFFF_FFFF;

  coverage_word_t pending_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int n_ok = 0, n_full = 0, n_bad = 0, n_cfg = 0;
  int stall_cycles = 0;

  interval_union_coverage #(
    .MAX_RANGES(SLOTS),
    .POSITION_BITS(32)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),     // range_start[31:0], range_end[63:32]
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),     // uncovered_cells[31:0], range_count[38:32], pad[39]
    .m_tuser(m_tuser),     // status[1:0]
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit adjoins(logic [31:0] alo, logic [31:0] ahi,
                                 logic [31:0] blo, logic [31:0] bhi);
    if (blo > ahi && blo - ahi > 32'd1) return 1'b0;
    if (alo > bhi && alo - bhi > 32'd1) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int live_spans();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (span_live[i]) n++;
    return n;
  endfunction

  // merge one accepted range into the table and queue the word it must produce
  function automatic void merge_range(logic [31:0] lo, logic [31:0] hi);
    coverage_word_t w;
    bit             hit [SLOTS];
    int             hits;
    logic [31:0]    mlo, mhi;
    bit             placed;
    hits = 0;
    placed = 1'b0;
    mlo = lo;
    mhi = hi;
    if (lo == 32'd0 || lo > hi || hi > line_cells) begin
      w.status = STATUS_BAD;
      n_bad++;
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        hit[i] = span_live[i] && adjoins(lo, hi, span_lo[i], span_hi[i]);
        if (hit[i]) begin
          hits++;
          if (span_lo[i] < mlo) mlo = span_lo[i];
          if (span_hi[i] > mhi) mhi = span_hi[i];
        end
      end
      if (hits == 0 && live_spans() >= SLOTS) begin
        w.status = STATUS_FULL;
        n_full++;
      end else begin
        for (int i = 0; i < SLOTS; i++) begin
          if (hit[i]) begin
            covered_cells = covered_cells - (span_hi[i] - span_lo[i] + 32'd1);
            span_live[i] = 1'b0;
          end
        end
        for (int i = 0; i < SLOTS && !placed; i++) begin
          if (!span_live[i]) begin
            span_live[i] = 1'b1;
            span_lo[i] = mlo;
            span_hi[i] = mhi;
            placed = 1'b1;
          end
        end
        covered_cells = covered_cells + (mhi - mlo + 32'd1);
        w.status = STATUS_OK;
        n_ok++;
      end
    end
    w.uncovered = (line_cells > covered_cells) ? line_cells - covered_cells : 32'd0;
    w.count = 7'(live_spans());
    pending_results.push_back(w);
  endfunction

  task automatic send_range(input logic [31:0] lo, input logic [31:0] hi);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {hi, lo};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    merge_range(lo, hi);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_total(input logic [31:0] value);
    drain_results();
    repeat (ITEM_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    line_cells = value;
    n_cfg++;
  endtask

  task automatic set_pacing(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    coverage_word_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: %h / %h", m_tdata, m_tuser);
        errors++;
      end else begin
        w = pending_results.pop_front();
        if (m_tdata[31:0] !== w.uncovered) begin
          $error("uncovered_cells: expected %0d, got %0d", w.uncovered, m_tdata[31:0]);
          errors++;
        end
        if (m_tdata[38:32] !== w.count) begin
          $error("range_count: expected %0d, got %0d", w.count, m_tdata[38:32]);
          errors++;
        end
        if (m_tdata[39] !== 1'b0) begin
          $error("pad: expected 0, got %b", m_tdata[39]);
          errors++;
        end
        if (m_tuser !== w.status) begin
          $error("status: expected %0d, got %0d", w.status, m_tuser);
          errors++;
        end
      end
    end
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // extremes, merges on both sides, bad ranges, total lowered below coverage
  task automatic test_directed();
    set_total(32'hFFFF_FFFF);
    send_range(32'd0, 32'd5);
    send_range(32'd10, 32'd9);
    send_range(32'd5, 32'd5);
    send_range(32'd7, 32'd8);
    send_range(32'd6, 32'd6);
    send_range(32'd9, 32'd9);
    send_range(32'd4, 32'd4);
    send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_range(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_range(32'h8000_0000, 32'h7FFF_FFFF);
    set_total(32'd100);
    send_range(32'd1, 32'd100);
    send_range(32'd50, 32'd101);
    send_range(32'd100, 32'd100);
    set_total(32'd1);
    send_range(32'd1, 32'd1);
    send_range(32'd1, 32'd2);
    send_range(32'd2, 32'd2);
    send_range(32'd0, 32'd0);
  endtask

  // isolated single cells until the table overflows, then mixed merges
  task automatic test_table_full();
    logic [31:0] pos;
    set_total(32'd100000);
    for (int i = 0; i < 70; i++) begin
      pos = 32'd1000 + 32'(2 * i);
      send_range(pos, pos);
    end
    for (int i = 0; i < 40; i++) begin
      pos = 32'd1000 + $urandom_range(170);
      send_range(pos, pos + $urandom_range(2));
    end
    send_range(32'd1000, 32'd1200);
  endtask

  task automatic random_window(input int n_items);
    logic [31:0] base, top, lo, hi;
    int          span;
    span = $urandom_range(400, 64);
    base = $urandom_range(32'hFFFF_F000, 1);
    top = base + span - 1;
    set_total(($urandom_range(3) == 0) ? 32'hFFFF_FFFF : top + $urandom_range(50));
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < 85) begin
        lo = base + $urandom_range(span - 1);
        if ($urandom_range(9) < 8) hi = lo + $urandom_range(5);
        else hi = lo + $urandom_range(span / 3);
        if (hi > top) hi = top;
      end else begin
        case ($urandom_range(3))
          0: begin
            lo = 32'd0;
            hi = $urandom;
          end
          1: begin
            lo = $urandom;
            hi = $urandom;
          end
          2: begin
            if (line_cells < 32'hFFFF_0000) begin
              lo = base;
              hi = line_cells + $urandom_range(1000, 1);
            end else begin
              lo = 32'd0;
              hi = base;
            end
          end
          default: begin
            hi = base + $urandom_range(span - 1);
            lo = hi + $urandom_range(8, 1);
          end
        endcase
      end
      send_range(lo, hi);
    end
    send_range(base, top);
  endtask

  task automatic test_random_ranges(input int n_windows);
    for (int k = 0; k < n_windows; k++) random_window($urandom_range(200, 160));
  endtask

  initial begin
    set_pacing(8, 61);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_table_full();
    test_random_ranges(2);
    set_pacing(61, 8);
    test_random_ranges(2);
    set_pacing(0, 0);
    test_random_ranges(2);
    drain_results();
    repeat (ITEM_CYCLES) @(posedge clk);
    $display("ranges sent: %0d merged, %0d dropped on a full table, %0d rejected",
             n_ok, n_full, n_bad);
    $display("total_cells written %0d times under three stall patterns", n_cfg);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
